// ===== rtl/core/aes128_block_cipher_ecb_cbc_macros.svh =====
// ----------------------------------------------------------------------------
// aes128_block_cipher_ecb_cbc_macros
// Assertion macros for the AES-128 core.
// ----------------------------------------------------------------------------
`ifndef AES128_BLOCK_CIPHER_ECB_CBC_MACROS_SVH
`define AES128_BLOCK_CIPHER_ECB_CBC_MACROS_SVH

// implication checked every cycle out of reset
`define AES_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AES_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// Types, constants and byte functions shared by the AES-128 core.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned ROUNDS_DEF = 10;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_HIGH   = 3'd0,
    REG_KEY_LOW    = 3'd1,
    REG_IV_HIGH    = 3'd2,
    REG_IV_LOW     = 3'd3,
    REG_CHAIN_MODE = 3'd4,
    REG_DIRECTION  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        restart_chain;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input word, start
    logic rnd;       // run one round
    logic last;      // this round is the final one
    logic finish;    // write result, update chain
  } dp_cmd_t;

  // controller -> key expander
  typedef struct packed {
    logic start;
    logic step;
  } kx_cmd_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] isbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

// ===== rtl/core/aes_keyx.sv =====
// ----------------------------------------------------------------------------
// aes_keyx
// Round key expander: one round key per step into an 11-entry key store.
// ----------------------------------------------------------------------------
module aes_keyx import aes_pkg::*; #(
  parameter int unsigned ROUNDS = ROUNDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kx_cmd_t                       cmd,
  input  logic [127:0]                  key,
  input  logic [$clog2(ROUNDS+1)-1:0]   rd_idx,
  output logic [127:0]                  rd_key
);

  localparam int unsigned RW = $clog2(ROUNDS + 1);

  logic [127:0] keys_r [ROUNDS+1];
  logic [127:0] cur_r;
  logic [7:0]   rcon_r;
  logic [RW-1:0] wr_r;
  logic [127:0] next_key;
  logic [31:0]  t, w0, w1, w2, w3;

  always_comb begin
    t  = sub_word({cur_r[23:0], cur_r[31:24]}) ^ {rcon_r, 24'h0};
    w0 = cur_r[127:96] ^ t;
    w1 = cur_r[95:64] ^ w0;
    w2 = cur_r[63:32] ^ w1;
    w3 = cur_r[31:0] ^ w2;
    next_key = {w0, w1, w2, w3};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcon_r <= 8'h01;
      wr_r   <= '0;
    end else if (cmd.start) begin
      rcon_r <= 8'h01;
      wr_r   <= RW'(1);
    end else if (cmd.step) begin
      rcon_r <= xt(rcon_r);
      wr_r   <= wr_r + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_r     <= key;
      keys_r[0] <= key;
    end else if (cmd.step) begin
      cur_r        <= next_key;
      keys_r[wr_r] <= next_key;
    end
  end

  assign rd_key = keys_r[rd_idx];

endmodule

// ===== rtl/core/aes_dp.sv =====
// ----------------------------------------------------------------------------
// aes_dp
// Cipher datapath: state register, one round per cycle, chaining and result.
// ----------------------------------------------------------------------------
module aes_dp import aes_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  dp_cmd_t      cmd,
  input  in_word_t     in_word,
  input  logic [127:0] rkey,
  input  logic [127:0] iv,
  input  logic         cbc,
  input  logic         dec,
  output out_word_t    out_word
);

  logic [127:0] st_r, chain_r, ct_in_r;
  out_word_t    out_r;
  logic [127:0] blk, chain_use, st_nxt, fin;
  logic [7:0]   s  [16];
  logic [7:0]   ss [16];
  logic [7:0]   m  [16];
  logic [7:0]   a  [16];
  logic [7:0]   b2, b4, b8, x0, x1, x2, x3;
  int r, c;

  assign blk       = {in_word.block_high, in_word.block_low};
  assign chain_use = in_word.restart_chain ? iv : chain_r;

  always_comb begin
    b2 = '0;
    b4 = '0;
    b8 = '0;
    for (int i = 0; i < 16; i++) s[i] = st_r[127-8*i -: 8];
    for (int i = 0; i < 16; i++) ss[i] = '0;
    // sub bytes + shift rows (or inverse)
    for (int i = 0; i < 16; i++) begin
      r = i % 4; c = i / 4;
      if (dec) ss[r + 4*((c + r) % 4)] = isbox(s[i]);
      else     ss[i] = sbox(s[r + 4*((c + r) % 4)]);
    end
    // decrypt order: shift/sub, add key, inv mix
    for (int i = 0; i < 16; i++) a[i] = dec ? (ss[i] ^ rkey[127-8*i -: 8]) : ss[i];
    for (int cc = 0; cc < 4; cc++) begin
      for (int rr = 0; rr < 4; rr++) begin
        x0 = a[4*cc + rr];
        x1 = a[4*cc + (rr+1)%4];
        x2 = a[4*cc + (rr+2)%4];
        x3 = a[4*cc + (rr+3)%4];
        if (dec) begin
          // 14*x0 ^ 11*x1 ^ 13*x2 ^ 9*x3
          b2 = xt(x0); b4 = xt(b2); b8 = xt(b4);
          m[4*cc+rr] = b8 ^ b4 ^ b2;
          b2 = xt(x1); b4 = xt(b2); b8 = xt(b4);
          m[4*cc+rr] = m[4*cc+rr] ^ b8 ^ b2 ^ x1;
          b2 = xt(x2); b4 = xt(b2); b8 = xt(b4);
          m[4*cc+rr] = m[4*cc+rr] ^ b8 ^ b4 ^ x2;
          b2 = xt(x3); b4 = xt(b2); b8 = xt(b4);
          m[4*cc+rr] = m[4*cc+rr] ^ b8 ^ x3;
        end else begin
          b2 = xt(x0);
          m[4*cc+rr] = b2 ^ xt(x1) ^ x1 ^ x2 ^ x3;
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (cmd.last) st_nxt[127-8*i -: 8] = dec ? a[i] : (ss[i] ^ rkey[127-8*i -: 8]);
      else if (dec) st_nxt[127-8*i -: 8] = m[i];
      else          st_nxt[127-8*i -: 8] = m[i] ^ rkey[127-8*i -: 8];
    end
  end

  always_comb begin
    fin = st_r;
    if (dec && cbc) fin = st_r ^ chain_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
    end else if (cmd.load) begin
      st_r    <= ((!dec && cbc) ? (blk ^ chain_use) : blk) ^ rkey;
      ct_in_r <= blk;
      if (in_word.restart_chain) chain_r <= iv;
    end else if (cmd.rnd) begin
      st_r <= st_nxt;
    end else if (cmd.finish) begin
      out_r <= {fin[127:64], fin[63:0]};
      if (cbc) chain_r <= dec ? ct_in_r : st_r;
    end
  end

  assign out_word = out_r;

endmodule

// ===== rtl/core/aes_ctrl.sv =====
// ----------------------------------------------------------------------------
// aes_ctrl
// Sequencer: key expansion after key writes, round count, output handshake.
// ----------------------------------------------------------------------------
module aes_ctrl import aes_pkg::*; #(
  parameter int unsigned ROUNDS = ROUNDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        key_wr,
  input  logic                        dec,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dp_cmd_t                     dcmd,
  output kx_cmd_t                     kcmd,
  output logic [$clog2(ROUNDS+1)-1:0] kidx
);

  `include "aes128_block_cipher_ecb_cbc_macros.svh"

  localparam int unsigned RW = $clog2(ROUNDS + 1);

  typedef enum logic [3:0] {
    S_KEYX = 4'b0001,
    S_IDLE = 4'b0010,
    S_RUN  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [RW-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic kx_pend_r, kx_pend_nxt;
  logic accept;

  // a waiting result does not block the input; the result write waits instead
  assign in_ready = (state_r == S_IDLE) && !kx_pend_r;
  assign accept   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    kx_pend_nxt   = kx_pend_r | key_wr;
    out_valid_nxt = out_valid_r && !out_ready;
    dcmd          = '0;
    kcmd          = '0;
    kidx          = '0;
    case (state_r)
      S_KEYX: begin
        kcmd.step = 1'b1;
        cnt_nxt   = cnt_r + RW'(1);
        if (cnt_r == RW'(ROUNDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        kidx = dec ? RW'(ROUNDS) : '0;
        if (kx_pend_r) begin
          kcmd.start  = 1'b1;
          kx_pend_nxt = key_wr;
          cnt_nxt     = '0;
          state_nxt   = S_KEYX;
        end else if (accept) begin
          dcmd.load = 1'b1;
          cnt_nxt   = RW'(1);
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        kidx      = dec ? RW'(ROUNDS) - cnt_r : cnt_r;
        dcmd.rnd  = 1'b1;
        dcmd.last = (cnt_r == RW'(ROUNDS));
        cnt_nxt   = cnt_r + RW'(1);
        if (dcmd.last) state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free or being drained
        if (!out_valid_r || out_ready) begin
          dcmd.finish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      kx_pend_r   <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      kx_pend_r   <= kx_pend_nxt;
    end
  end

  `AES_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_r), "state not one-hot")
  `AES_ASSERT_IMP(a_done_free, clk, rst_n, dcmd.finish, !out_valid_r || out_ready,
    "result register overwritten")
  `AES_ASSERT_NXT(a_acc_run, clk, rst_n, accept, state_r == S_RUN, "accept did not start run")
  `AES_ASSERT_IMP(a_cnt, clk, rst_n, state_r == S_RUN, cnt_r != '0, "round count zero in run")

endmodule

// ===== rtl/core/aes128_block_cipher_ecb_cbc.sv =====
// ----------------------------------------------------------------------------
// aes128_block_cipher_ecb_cbc
// AES-128 ECB/CBC encrypt/decrypt core with configuration registers.
// ----------------------------------------------------------------------------
//  channel | signals                        | word
//  in      | in_valid/in_ready/in_data      | block halves + restart flag
//  out     | out_valid/out_ready/out_data   | result halves
//  cfg     | cfg_valid/cfg_ready/cfg_idx/.. | register index + 64-bit data
//
// After the accepting edge the block passes the first key addition at
// accept, ten rounds and the result write, all in the single shared round
// unit; the next block is taken only once the core is back in idle. A new
// block is taken while the previous result waits; its result write holds
// until the output drains. A key write re-runs the key expansion before the
// next block; reset starts that expansion as well.
// ----------------------------------------------------------------------------
module aes128_block_cipher_ecb_cbc import aes_pkg::*; #(
  parameter int unsigned ROUNDS = ROUNDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [63:0]          cfg_data
);

  localparam int unsigned RW = $clog2(ROUNDS + 1);

  logic [63:0] key_high_r, key_low_r, iv_high_r, iv_low_r;
  logic        chain_mode_r, direction_r;
  logic        cfg_wr, key_wr;
  dp_cmd_t     dcmd;
  kx_cmd_t     kcmd;
  logic [RW-1:0] kidx;
  logic [127:0]  rkey;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign key_wr    = cfg_wr && (cfg_idx == REG_KEY_HIGH || cfg_idx == REG_KEY_LOW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r   <= '0;
      key_low_r    <= '0;
      iv_high_r    <= '0;
      iv_low_r     <= '0;
      chain_mode_r <= 1'b0;
      direction_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KEY_HIGH:   key_high_r   <= cfg_data;
        REG_KEY_LOW:    key_low_r    <= cfg_data;
        REG_IV_HIGH:    iv_high_r    <= cfg_data;
        REG_IV_LOW:     iv_low_r     <= cfg_data;
        REG_CHAIN_MODE: chain_mode_r <= cfg_data[0];
        REG_DIRECTION:  direction_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  aes_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
    .clk, .rst_n, .key_wr, .dec(direction_r),
    .in_valid, .in_ready, .out_valid, .out_ready,
    .dcmd, .kcmd, .kidx
  );

  aes_keyx #(.ROUNDS(ROUNDS)) u_keyx (
    .clk, .rst_n, .cmd(kcmd), .key({key_high_r, key_low_r}),
    .rd_idx(kidx), .rd_key(rkey)
  );

  aes_dp u_dp (
    .clk, .rst_n, .cmd(dcmd), .in_word(in_data), .rkey,
    .iv({iv_high_r, iv_low_r}), .cbc(chain_mode_r), .dec(direction_r),
    .out_word(out_data)
  );

endmodule

// ===== test/tb_aes128_block_cipher_ecb_cbc.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aes128_block_cipher_ecb_cbc
// Self-checking bench for the AES-128 ECB/CBC core. A behavioral cipher
// tracks key, IV and chaining value and predicts every result word, which a
// monitor compares in order. Directed cases are followed by randomized phases
// across all mode and direction settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_aes128_block_cipher_ecb_cbc;
  import aes_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_word_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [63:0]          cfg_data;

  aes128_block_cipher_ecb_cbc DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  // cipher model state
  logic [7:0]   fwd_sb [256];
  logic [7:0]   inv_sb [256];
  logic [127:0] key_reg, iv_reg, chain_reg;
  logic         cbc_mode, decrypt_mode;
  logic [127:0] rkey [11];

  out_word_t pending_results [$];
  int        errors = 0;
  int        blocks_sent = 0;
  int        cfg_writes = 0;
  int        results_seen = 0;
  bit        long_hold = 0;

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b = b >> 1;
    end
    return p;
  endfunction

  // S-box from the field inverse and the affine map
  function automatic void build_boxes();
    logic [7:0] iv, b;
    for (int x = 0; x < 256; x++) begin
      iv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) iv = y[7:0];
      b = iv ^ {iv[6:0], iv[7]} ^ {iv[5:0], iv[7:6]} ^ {iv[4:0], iv[7:5]}
          ^ {iv[3:0], iv[7:4]} ^ 8'h63;
      fwd_sb[x] = b;
      inv_sb[b] = x[7:0];
    end
  endfunction

  function automatic logic [7:0] byte_at(logic [127:0] s, int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key_reg[127-32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if ((i % 4) == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_sb[t[31:24]], fwd_sb[t[23:16]], fwd_sb[t[15:8]], fwd_sb[t[7:0]]};
        t ^= {rc, 24'h0};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) rkey[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  function automatic logic [127:0] sub_shift(logic [127:0] s, bit inv);
    logic [127:0] t;
    t = '0;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        if (inv) t[127-8*(r+4*((c+r)%4)) -: 8] = inv_sb[byte_at(s, r+4*c)];
        else     t[127-8*(r+4*c) -: 8] = fwd_sb[byte_at(s, r+4*((c+r)%4))];
      end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(logic [127:0] s, bit inv);
    logic [7:0]   m [4];
    logic [7:0]   v;
    logic [127:0] t;
    if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else     m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int j = 0; j < 4; j++) v ^= gf_mul(m[(j-r+4)%4], byte_at(s, 4*c+j));
        t[127-8*(4*c+r) -: 8] = v;
      end
    return t;
  endfunction

  function automatic logic [127:0] cipher_fwd(logic [127:0] s);
    s ^= rkey[0];
    for (int r = 1; r < 10; r++) s = mix_cols(sub_shift(s, 0), 0) ^ rkey[r];
    return sub_shift(s, 0) ^ rkey[10];
  endfunction

  function automatic logic [127:0] cipher_inv(logic [127:0] s);
    s = sub_shift(s ^ rkey[10], 1);
    for (int r = 9; r > 0; r--) s = sub_shift(mix_cols(s ^ rkey[r], 1), 1);
    return s ^ rkey[0];
  endfunction

  // next result word for one block, advancing the chaining value
  function automatic out_word_t aes_next_result(in_word_t w);
    logic [127:0] blk, res;
    blk = {w.block_high, w.block_low};
    if (w.restart_chain) chain_reg = iv_reg;
    if (!decrypt_mode) begin
      res = cipher_fwd(cbc_mode ? blk ^ chain_reg : blk);
      if (cbc_mode) chain_reg = res;
    end else begin
      res = cipher_inv(blk);
      if (cbc_mode) begin
        res ^= chain_reg;
        chain_reg = blk;
      end
    end
    return '{result_high: res[127:64], result_low: res[63:0]};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(6_000_000);
    $display("timeout at %0t", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

  // result monitor
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %h", $time, out_data);
      end else begin
        exp_w = pending_results.pop_front();
        if (out_data.result_high !== exp_w.result_high) begin
          errors++;
          $display("%0t: result_high exp %h got %h", $time, exp_w.result_high,
                   out_data.result_high);
        end
        if (out_data.result_low !== exp_w.result_low) begin
          errors++;
          $display("%0t: result_low exp %h got %h", $time, exp_w.result_low,
                   out_data.result_low);
        end
      end
    end
  end

  // result receiver; the long hold lets the core back up into its input
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 0;
      end
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_block(logic [63:0] hi, logic [63:0] lo, bit restart,
                            bit no_gap = 0);
    int gap;
    in_word_t w;
    gap = no_gap ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    w = '{block_high: hi, block_low: lo, restart_chain: restart};
    pending_results.push_back(aes_next_result(w));
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    blocks_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // cfg_valid is dropped after each accepted write before the task returns
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_idx   <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    cfg_writes++;
    case (idx)
      REG_KEY_HIGH:   begin key_reg[127:64] = data; expand_round_keys(); end
      REG_KEY_LOW:    begin key_reg[63:0] = data; expand_round_keys(); end
      REG_IV_HIGH:    iv_reg[127:64] = data;
      REG_IV_LOW:     iv_reg[63:0] = data;
      REG_CHAIN_MODE: cbc_mode = data[0];
      REG_DIRECTION:  decrypt_mode = data[0];
      default: ;
    endcase
  endtask

  task automatic set_mode(bit cbc, bit dec);
    write_reg(REG_CHAIN_MODE, {$urandom, 31'($urandom), cbc});
    write_reg(REG_DIRECTION, {$urandom, 31'($urandom), dec});
  endtask

  task automatic test_reset_defaults();
    // zero key, ECB encrypt straight out of reset
    send_block(64'h0, 64'h0, 0);
    send_block('1, '1, 1);
    drain();
  endtask

  task automatic test_known_vector();
    write_reg(REG_KEY_HIGH, 64'h0001020304050607);
    write_reg(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    set_mode(0, 0);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 0);
    drain();
    set_mode(0, 1);
    send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 0);
    drain();
  endtask

  task automatic test_cbc_chaining();
    write_reg(REG_IV_HIGH, '1);
    write_reg(REG_IV_LOW, 64'h0123456789abcdef);
    for (int d = 0; d < 2; d++) begin
      set_mode(1, d[0]);
      send_block(64'h0, 64'h0, 1);
      send_block('1, '1, 0);
      send_block(rand64(), rand64(), 0);
      // new IV is held back until the next restart
      drain();
      write_reg(REG_IV_HIGH, 64'h0);
      send_block(rand64(), rand64(), 0);
      send_block(rand64(), rand64(), 1);
      drain();
    end
  endtask

  task automatic test_ecb_restart();
    // restart in ECB still reloads the chain for a later CBC block
    write_reg(REG_IV_LOW, rand64());
    set_mode(0, 0);
    send_block(rand64(), rand64(), 1);
    drain();
    set_mode(1, 0);
    send_block(rand64(), rand64(), 0);
    drain();
  endtask

  task automatic test_unknown_index();
    write_reg(3'd6, rand64());
    write_reg(3'd7, '1);
    send_block(rand64(), rand64(), 0);
    drain();
  endtask

  task automatic test_backpressure();
    set_mode(1, 1);
    long_hold = 1;
    for (int i = 0; i < 30; i++) send_block(rand64(), rand64(), i == 0, 1);
    drain();
  endtask

  task automatic test_random_phases();
    logic [63:0] kh, kl;
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin kh = '0; kl = '0; end
        1: begin kh = '1; kl = '1; end
        default: begin kh = rand64(); kl = rand64(); end
      endcase
      write_reg(REG_KEY_HIGH, kh);
      write_reg(REG_KEY_LOW, kl);
      write_reg(REG_IV_HIGH, (ph == 5) ? '1 : rand64());
      write_reg(REG_IV_LOW, (ph == 6) ? '0 : rand64());
      set_mode(ph[0], ph[1]);
      for (int i = 0; i < 85; i++) begin
        case ($urandom_range(0, 15))
          0:       send_block('0, '0, $urandom_range(0, 9) == 0);
          1:       send_block('1, '1, $urandom_range(0, 9) == 0);
          default: send_block(rand64(), rand64(), i == 0 || $urandom_range(0, 9) == 0);
        endcase
      end
      drain();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_idx   = REG_KEY_HIGH;
    cfg_data  = '0;
    build_boxes();
    key_reg = '0; iv_reg = '0; chain_reg = '0;
    cbc_mode = 0; decrypt_mode = 0;
    expand_round_keys();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_known_vector();
    test_cbc_chaining();
    test_ecb_restart();
    test_unknown_index();
    test_backpressure();
    test_random_phases();

    $display("%0d blocks, %0d results, %0d register writes", blocks_sent,
             results_seen, cfg_writes);
    $display("ECB/CBC in both directions, key/IV extremes, restarts, long stall");
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
